@@ hw/rtl/drt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants of the divider and reload timer
// field widths, register indexes and the period decode
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int CyclesW  = 6;
  localparam int ByteW    = 8;
  localparam int SysCntW  = 16;
  localparam int SelW     = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  // the widest period needs 10 low bits for the phase plus a carry bit for the boundary test
  localparam int PhaseW   = 11;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TIMER_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLOCK_SELECT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELOAD_VALUE = 2'd2;

  // clock select codes
  localparam logic [SelW-1:0] SEL_1024 = 2'd0;
  localparam logic [SelW-1:0] SEL_16   = 2'd1;
  localparam logic [SelW-1:0] SEL_64   = 2'd2;
  localparam logic [SelW-1:0] SEL_256  = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] divider_value;
    logic [ByteW-1:0] timer_value;
    logic             timer_irq;
  } result_t;

  // period length of the selected timer clock
  function automatic logic [PhaseW-1:0] period_of(input logic [SelW-1:0] sel);
    logic [PhaseW-1:0] p;
    case (sel)
      SEL_1024: p = 11'd1024;
      SEL_16:   p = 11'd16;
      SEL_64:   p = 11'd64;
      SEL_256:  p = 11'd256;
      default:  p = 11'd1024;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/divider_and_reload_timer.sv @@
`timescale 1ns / 1ps
// a result is registered in the output register, or held in the skid entry while the output stalls
// throughput: one item per cycle while the skid entry is free, set by the single-pass step logic in drt_count
// a two-entry output buffer keeps input acceptance going while one result waits
// reset: synchronous active-high rst clears counters, configuration and buffer
// ----------------------------------------------------------------------------
// divider_and_reload_timer: divider byte and reloadable timer counter
// each item adds elapsed clock cycles to a free-running system counter and
// reports the divider byte, the timer counter and an overflow interrupt pulse
// ----------------------------------------------------------------------------
module divider_and_reload_timer import drt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  // input items
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CyclesW-1:0]  elapsed_cycles,
  // result items
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ByteW-1:0]    divider_value,
  output logic [ByteW-1:0]    timer_value,
  output logic                timer_irq
);

  // configuration registers
  logic             timer_enable;
  logic [SelW-1:0]  clock_select;
  logic [ByteW-1:0] reload_value;

  logic    accept;
  logic    buf_full;
  result_t step_result;
  result_t out_data;

  // the input is held off only once the skid entry is occupied
  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  // register writes, an index past the last register is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_enable <= 1'b0;
      clock_select <= SEL_1024;
      reload_value <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TIMER_ENABLE: timer_enable <= cfg_data[0];
        CFG_CLOCK_SELECT: clock_select <= cfg_data[SelW-1:0];
        CFG_RELOAD_VALUE: reload_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // counter state, stepped once for every accepted item
  drt_count u_count (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .cycles       (elapsed_cycles),
    .timer_enable (timer_enable),
    .clock_select (clock_select),
    .reload_value (reload_value),
    .result       (step_result)
  );

  // result register and skid stage
  drt_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign divider_value = out_data.divider_value;
  assign timer_value   = out_data.timer_value;
  assign timer_irq     = out_data.timer_irq;

endmodule

@@ hw/rtl/drt_count.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_count: counter state and single-pass step logic
// holds system counter, divider and timer counter, advanced once per item
// ----------------------------------------------------------------------------
module drt_count import drt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [CyclesW-1:0] cycles,
  input  logic               timer_enable,
  input  logic [SelW-1:0]    clock_select,
  input  logic [ByteW-1:0]   reload_value,
  output result_t            result
);

  logic [SysCntW-1:0] system_counter;
  logic [ByteW-1:0]   divider_byte;
  logic [ByteW-1:0]   timer_counter;

  logic [SysCntW-1:0] system_counter_next;
  logic [ByteW-1:0]   divider_byte_next;
  logic [ByteW-1:0]   timer_counter_next;
  logic               irq;

  logic [ByteW:0]     low_sum;
  logic [PhaseW-1:0]  period;
  logic [PhaseW-1:0]  phase;
  logic [PhaseW-1:0]  phase_sum;
  logic               tick;

  always_comb begin
    low_sum   = {1'b0, system_counter[ByteW-1:0]} + {{(ByteW+1-CyclesW){1'b0}}, cycles};
    period    = period_of(clock_select);
    // position inside the current period
    phase     = system_counter[PhaseW-1:0] & (period - 11'd1);
    phase_sum = phase + {{(PhaseW-CyclesW){1'b0}}, cycles};
    tick      = timer_enable && (phase_sum >= period);

    system_counter_next = system_counter + {{(SysCntW-CyclesW){1'b0}}, cycles};
    divider_byte_next   = low_sum[ByteW] ? divider_byte + 8'd1 : divider_byte;
    timer_counter_next  = timer_counter;
    irq                 = 1'b0;
    if (tick) begin
      if (timer_counter == 8'hFF) begin
        timer_counter_next = reload_value;
        irq                = 1'b1;
      end else begin
        timer_counter_next = timer_counter + 8'd1;
      end
    end

    result.divider_value = divider_byte_next;
    result.timer_value   = timer_counter_next;
    result.timer_irq     = irq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      system_counter <= '0;
      divider_byte   <= '0;
      timer_counter  <= '0;
    end else if (advance) begin
      system_counter <= system_counter_next;
      divider_byte   <= divider_byte_next;
      timer_counter  <= timer_counter_next;
    end
  end

endmodule

@@ hw/rtl/drt_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_out_buf: result register with skid stage
// two-entry buffer so an item can be taken while a result is held
// ----------------------------------------------------------------------------
module drt_out_buf import drt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      // main register free next cycle, skid entry is older
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule
